@@ hdl/tqv_pkg.sv @@
// ----------------------------------------------------------------------------
// tqv_pkg
// Shared widths, constants and word types of the tile-to-quad vertex block.
// ----------------------------------------------------------------------------
package tqv_pkg;

  localparam int unsigned ID_W       = 32;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned TPR_W      = 14;
  localparam int unsigned TSZ_W      = 9;
  localparam int unsigned TEX_DIM_W  = 14;
  localparam int unsigned RGBA_W     = 32;
  localparam int unsigned CELL_W     = 10;
  localparam int unsigned POS_W      = 19;
  localparam int unsigned TEX_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MAP_DIM          = 1024;
  localparam int unsigned UV_FRAC_BITS_DEF = 16;

  // restoring divider, quotient bits per cycle
  localparam int unsigned DIV_STEP  = 3;
  localparam int unsigned DIV_W     = TEX_DIM_W;
  localparam int unsigned IDX_W     = CNT_W;
  localparam int unsigned IDX_ITERS = (IDX_W + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned IDX_QW    = IDX_ITERS * DIV_STEP;
  localparam int unsigned IDX_CW    = $clog2(IDX_ITERS + 1);

  localparam int unsigned QUEUE_DEPTH = 4;

  // corner order (0,0) (1,0) (0,1) (0,1) (1,0) (1,1), bit k = vertex k
  localparam int unsigned NVERT = 6;
  localparam int unsigned VTX_W = $clog2(NVERT);
  localparam logic [NVERT-1:0] CORNER_X = 6'b110010;
  localparam logic [NVERT-1:0] CORNER_Y = 6'b101100;
  localparam logic [VTX_W-1:0] LAST_VTX = VTX_W'(NVERT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_ID       = 3'd0,
    REG_SET_TILE_COUNT = 3'd1,
    REG_TILES_PER_ROW  = 3'd2,
    REG_TILE_WIDTH     = 3'd3,
    REG_TILE_HEIGHT    = 3'd4,
    REG_TEXTURE_WIDTH  = 3'd5,
    REG_TEXTURE_HEIGHT = 3'd6,
    REG_TINT_RGBA      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ID_W-1:0]      first_id;
    logic [CNT_W-1:0]     set_tile_count;
    logic [TPR_W-1:0]     tiles_per_row;
    logic [TSZ_W-1:0]     tile_width;
    logic [TSZ_W-1:0]     tile_height;
    logic [TEX_DIM_W-1:0] texture_width;
    logic [TEX_DIM_W-1:0] texture_height;
    logic [RGBA_W-1:0]    tint_rgba;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    first_id:       32'd1,
    set_tile_count: 16'd0,
    tiles_per_row:  14'd1,
    tile_width:     9'd16,
    tile_height:    9'd16,
    texture_width:  14'd256,
    texture_height: 14'd256,
    tint_rgba:      32'hFFFF_FFFF
  };

  typedef struct packed {
    logic [ID_W-1:0]   tile_id;
    logic [CELL_W-1:0] cell_col;
    logic [CELL_W-1:0] cell_row;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [TEX_W-1:0]  tex_u;
    logic [TEX_W-1:0]  tex_v;
    logic [RGBA_W-1:0] colour;
    logic              last_vertex;
  } out_word_t;

  // tile queued between front and back
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
  } q_item_t;

endpackage

@@ hdl/tqv_front.sv @@
// ----------------------------------------------------------------------------
// tqv_front
// Input register and tile classification: keeps tiles inside the tileset and
// the map, forwards the local index and cell to the queue, drops the rest.
// ----------------------------------------------------------------------------
module tqv_front
  import tqv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_push,
  output logic     in_full,
  input  in_word_t in_word,
  output logic     q_push,
  input  logic     q_full,
  output q_item_t  q_wdata
);

  logic       f_vld_r, f_vld_nxt;
  in_word_t   f_word_r;
  logic [ID_W:0] diff;
  logic       in_set, in_map, keep, advance, accept;

  assign diff    = {1'b0, f_word_r.tile_id} - {1'b0, cfg.first_id};
  assign in_set  = !diff[ID_W] && (diff[ID_W-1:CNT_W] == '0) &&
                   (diff[CNT_W-1:0] < cfg.set_tile_count);
  assign in_map  = (32'(f_word_r.cell_col) < MAP_DIM) &&
                   (32'(f_word_r.cell_row) < MAP_DIM);
  assign keep    = in_set && in_map;
  assign advance = f_vld_r && (!keep || !q_full);
  assign in_full = f_vld_r && !advance;
  assign accept  = in_push && !in_full;
  assign q_push  = f_vld_r && keep && !q_full;

  always_comb begin
    q_wdata.idx = diff[CNT_W-1:0];
    q_wdata.col = f_word_r.cell_col;
    q_wdata.row = f_word_r.cell_row;
  end

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (accept) begin
      f_vld_nxt = 1'b1;
    end else if (advance) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_word_r <= in_word;
    end
  end

endmodule

@@ hdl/tqv_fifo.sv @@
// ----------------------------------------------------------------------------
// tqv_fifo
// Short register queue of classified tiles between front and back.
// ----------------------------------------------------------------------------
module tqv_fifo
  import tqv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  q_item_t wdata,
  input  logic    pop,
  output logic    empty,
  output q_item_t rdata
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  q_item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_QW-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_QW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ hdl/tqv_back.sv @@
// ----------------------------------------------------------------------------
// tqv_back
// Vertex back end: tileset column/row divider, corner multiplies, four-lane
// texture coordinate divider and the six-vertex output stage.
// ----------------------------------------------------------------------------
module tqv_back
  import tqv_pkg::*;
#(
  parameter int unsigned UV_FRAC_BITS = UV_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  output logic      q_pop,
  input  q_item_t   q_rdata,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_word
);

  localparam int unsigned UV_ITERS = (UV_FRAC_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned UV_QW    = UV_ITERS * DIV_STEP;
  localparam int unsigned UV_EXTRA = UV_QW - UV_FRAC_BITS;
  localparam int unsigned UV_CW    = $clog2(UV_ITERS + 1);
  localparam int unsigned UVC_W    = UV_FRAC_BITS + 1;
  localparam int unsigned PROD_W   = IDX_W + 1 + TSZ_W;
  localparam int unsigned NLANE    = 4;

  typedef struct packed {
    logic [DIV_W-1:0]    rem;
    logic [DIV_STEP-1:0] q;
  } step_t;

  function automatic step_t div_step(input logic [DIV_W-1:0] rem_in,
                                     input logic [DIV_STEP-1:0] bits,
                                     input logic [DIV_W-1:0] dvs);
    step_t            s;
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    r   = rem_in;
    s.q = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, dvs}) begin
        t      = t - {1'b0, dvs};
        s.q[i] = 1'b1;
      end
      r = t[DIV_W-1:0];
    end
    s.rem = r;
    return s;
  endfunction

  function automatic logic [TEX_W-1:0] uv_fin(input logic sat,
                                              input logic [UV_QW-1:0] quo);
    logic [UVC_W-1:0] c;
    c = sat ? {1'b1, {UV_FRAC_BITS{1'b0}}} : UVC_W'(quo >> UV_EXTRA);
    return TEX_W'(c);
  endfunction

  // ---------------- stage A: idx / tiles_per_row ----------------
  logic                a_vld_r, a_vld_nxt;
  logic [IDX_CW-1:0]   a_cnt_r, a_cnt_nxt;
  logic [DIV_W-1:0]    a_rem_r, a_rem_nxt, a_rem_in;
  logic [IDX_QW-1:0]   a_dvd_r, a_dvd_nxt, a_dvd_in, a_quo_r, a_quo_nxt;
  logic [CELL_W-1:0]   a_col_r, a_col_nxt, a_row_r, a_row_nxt;
  logic                a_done, a_run, a_hand, a_load;
  step_t               a_step;

  // ---------------- stage B: multiplies ----------------
  logic                b_vld_r, b_vld_nxt, b_rdy;
  logic [PROD_W-1:0]   b_num_r [NLANE];
  logic [PROD_W-1:0]   b_num_nxt [NLANE];
  logic [POS_W-1:0]    b_px_r [2];
  logic [POS_W-1:0]    b_py_r [2];
  logic [POS_W-1:0]    b_px_nxt [2];
  logic [POS_W-1:0]    b_py_nxt [2];

  // ---------------- stage C: uv divide ----------------
  logic                c_vld_r, c_vld_nxt, c_free, c_load, c_done, c_run, c_hand;
  logic [UV_CW-1:0]    c_cnt_r, c_cnt_nxt;
  logic [DIV_W-1:0]    c_rem_r [NLANE];
  logic [DIV_W-1:0]    c_rem_nxt [NLANE];
  logic [UV_QW-1:0]    c_quo_r [NLANE];
  logic [UV_QW-1:0]    c_quo_nxt [NLANE];
  logic                c_sat_r [NLANE];
  logic                c_sat_nxt [NLANE];
  logic [DIV_W-1:0]    c_dvs [NLANE];
  step_t               c_step [NLANE];
  logic [POS_W-1:0]    c_px_r [2];
  logic [POS_W-1:0]    c_py_r [2];

  // ---------------- stage D: vertex output ----------------
  logic                d_vld_r, d_vld_nxt, d_rdy;
  logic [VTX_W-1:0]    d_k_r, d_k_nxt;
  logic [POS_W-1:0]    d_px_r [2];
  logic [POS_W-1:0]    d_py_r [2];
  logic [TEX_W-1:0]    d_u_r [2];
  logic [TEX_W-1:0]    d_v_r [2];

  // handshakes between stages
  assign a_done = a_vld_r && (a_cnt_r == IDX_CW'(IDX_ITERS));
  assign a_run  = a_vld_r && !a_done;
  assign a_hand = a_done && b_rdy;
  assign a_load = !q_empty && (!a_vld_r || a_hand);
  assign q_pop  = a_load;

  assign c_done = c_vld_r && (c_cnt_r == UV_CW'(UV_ITERS));
  assign c_run  = c_vld_r && !c_done;
  assign c_hand = c_done && d_rdy;
  assign c_free = !c_vld_r || c_hand;
  assign c_load = b_vld_r && c_free;
  assign b_rdy  = !b_vld_r || c_free;

  assign d_rdy  = !d_vld_r || (out_pop && (d_k_r == LAST_VTX));

  // stage A
  assign a_dvd_in = a_load ? IDX_QW'(q_rdata.idx) : a_dvd_r;
  assign a_rem_in = a_load ? '0 : a_rem_r;
  assign a_step   = div_step(a_rem_in, a_dvd_in[IDX_QW-1 -: DIV_STEP],
                             DIV_W'(cfg.tiles_per_row));

  always_comb begin
    a_vld_nxt = a_vld_r;
    a_cnt_nxt = a_cnt_r;
    a_rem_nxt = a_rem_r;
    a_quo_nxt = a_quo_r;
    a_dvd_nxt = a_dvd_r;
    a_col_nxt = a_col_r;
    a_row_nxt = a_row_r;
    if (a_load) begin
      a_vld_nxt = 1'b1;
      a_cnt_nxt = IDX_CW'(1);
      a_rem_nxt = a_step.rem;
      a_quo_nxt = IDX_QW'(a_step.q);
      a_dvd_nxt = a_dvd_in << DIV_STEP;
      a_col_nxt = q_rdata.col;
      a_row_nxt = q_rdata.row;
    end else if (a_run) begin
      a_cnt_nxt = a_cnt_r + 1'b1;
      a_rem_nxt = a_step.rem;
      a_quo_nxt = {a_quo_r[IDX_QW-DIV_STEP-1:0], a_step.q};
      a_dvd_nxt = a_dvd_in << DIV_STEP;
    end else if (a_hand) begin
      a_vld_nxt = 1'b0;
    end
  end

  // stage B: remainder is the tileset column, quotient the tileset row
  always_comb begin
    b_num_nxt[0] = PROD_W'(a_rem_r) * PROD_W'(cfg.tile_width);
    b_num_nxt[1] = (PROD_W'(a_rem_r) + PROD_W'(1)) * PROD_W'(cfg.tile_width);
    b_num_nxt[2] = PROD_W'(a_quo_r[IDX_W-1:0]) * PROD_W'(cfg.tile_height);
    b_num_nxt[3] = (PROD_W'(a_quo_r[IDX_W-1:0]) + PROD_W'(1)) *
                   PROD_W'(cfg.tile_height);
    b_px_nxt[0]  = POS_W'(a_col_r) * POS_W'(cfg.tile_width);
    b_px_nxt[1]  = (POS_W'(a_col_r) + POS_W'(1)) * POS_W'(cfg.tile_width);
    b_py_nxt[0]  = POS_W'(a_row_r) * POS_W'(cfg.tile_height);
    b_py_nxt[1]  = (POS_W'(a_row_r) + POS_W'(1)) * POS_W'(cfg.tile_height);
    b_vld_nxt    = b_vld_r;
    if (a_hand) begin
      b_vld_nxt = 1'b1;
    end else if (c_load) begin
      b_vld_nxt = 1'b0;
    end
  end

  // stage C: lanes u0 u1 v0 v1
  always_comb begin
    c_vld_nxt = c_vld_r;
    c_cnt_nxt = c_cnt_r;
    if (c_load) begin
      c_vld_nxt = 1'b1;
      c_cnt_nxt = UV_CW'(1);
    end else if (c_run) begin
      c_cnt_nxt = c_cnt_r + 1'b1;
    end else if (c_hand) begin
      c_vld_nxt = 1'b0;
    end
    for (int l = 0; l < NLANE; l++) begin
      c_dvs[l]     = (l < 2) ? cfg.texture_width : cfg.texture_height;
      c_step[l]    = div_step(c_load ? b_num_r[l][DIV_W-1:0] : c_rem_r[l], '0,
                              c_dvs[l]);
      c_rem_nxt[l] = c_rem_r[l];
      c_quo_nxt[l] = c_quo_r[l];
      c_sat_nxt[l] = c_sat_r[l];
      if (c_load) begin
        c_rem_nxt[l] = c_step[l].rem;
        c_quo_nxt[l] = UV_QW'(c_step[l].q);
        c_sat_nxt[l] = (b_num_r[l] >= PROD_W'(c_dvs[l]));
      end else if (c_run) begin
        c_rem_nxt[l] = c_step[l].rem;
        c_quo_nxt[l] = {c_quo_r[l][UV_QW-DIV_STEP-1:0], c_step[l].q};
      end
    end
  end

  // stage D
  always_comb begin
    d_vld_nxt = d_vld_r;
    d_k_nxt   = d_k_r;
    if (c_hand) begin
      d_vld_nxt = 1'b1;
      d_k_nxt   = '0;
    end else if (d_vld_r && out_pop) begin
      if (d_k_r == LAST_VTX) begin
        d_vld_nxt = 1'b0;
      end else begin
        d_k_nxt = d_k_r + 1'b1;
      end
    end
  end

  assign out_empty = !d_vld_r;

  always_comb begin
    out_word.pos_x       = CORNER_X[d_k_r] ? d_px_r[1] : d_px_r[0];
    out_word.pos_y       = CORNER_Y[d_k_r] ? d_py_r[1] : d_py_r[0];
    out_word.tex_u       = CORNER_X[d_k_r] ? d_u_r[1] : d_u_r[0];
    out_word.tex_v       = CORNER_Y[d_k_r] ? d_v_r[1] : d_v_r[0];
    out_word.colour      = cfg.tint_rgba;
    out_word.last_vertex = (d_k_r == LAST_VTX);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      a_cnt_r <= '0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      c_cnt_r <= '0;
      d_vld_r <= 1'b0;
      d_k_r   <= '0;
    end else begin
      a_vld_r <= a_vld_nxt;
      a_cnt_r <= a_cnt_nxt;
      b_vld_r <= b_vld_nxt;
      c_vld_r <= c_vld_nxt;
      c_cnt_r <= c_cnt_nxt;
      d_vld_r <= d_vld_nxt;
      d_k_r   <= d_k_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    a_rem_r <= a_rem_nxt;
    a_quo_r <= a_quo_nxt;
    a_dvd_r <= a_dvd_nxt;
    a_col_r <= a_col_nxt;
    a_row_r <= a_row_nxt;
    for (int l = 0; l < NLANE; l++) begin
      c_rem_r[l] <= c_rem_nxt[l];
      c_quo_r[l] <= c_quo_nxt[l];
      c_sat_r[l] <= c_sat_nxt[l];
    end
    if (a_hand) begin
      for (int l = 0; l < NLANE; l++) begin
        b_num_r[l] <= b_num_nxt[l];
      end
      for (int j = 0; j < 2; j++) begin
        b_px_r[j] <= b_px_nxt[j];
        b_py_r[j] <= b_py_nxt[j];
      end
    end
    if (c_load) begin
      for (int j = 0; j < 2; j++) begin
        c_px_r[j] <= b_px_r[j];
        c_py_r[j] <= b_py_r[j];
      end
    end
    if (c_hand) begin
      for (int j = 0; j < 2; j++) begin
        d_px_r[j] <= c_px_r[j];
        d_py_r[j] <= c_py_r[j];
        d_u_r[j]  <= uv_fin(c_sat_r[j], c_quo_r[j]);
        d_v_r[j]  <= uv_fin(c_sat_r[j+2], c_quo_r[j+2]);
      end
    end
  end

endmodule

@@ hdl/tile_to_quad_vertex_gen_unit.sv @@
// ----------------------------------------------------------------------------
// tile_to_quad_vertex_gen_unit
// Turns map tiles of the configured tileset into six quad vertices each.
//
//   port group   dir   handshake              word
//   in_*         in    in_push / in_full      in_word_t  tile id, cell col/row
//   out_*        out   out_pop / out_empty    out_word_t one vertex
//   cfg_*        in    cfg_we                 cfg_idx, cfg_wdata
//
// One tile in range: six result words, one per cycle while out_pop is held.
// Sustained tile rate is set by the six vertex pops and the 3-bit-per-cycle
// texture coordinate divider; stages overlap, so a tile can start before the
// last one's vertices are out. Dropped tiles leave the input register without
// waiting on the queue, even while the queue is full.
// rst_n is synchronous; it empties the pipe and restores register defaults.
// ----------------------------------------------------------------------------
module tile_to_quad_vertex_gen_unit
  import tqv_pkg::*;
#(
  parameter int unsigned UV_FRAC_BITS = UV_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_word_t              in_word,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt, cfg_eff;
  logic    q_push, q_full, q_pop, q_empty;
  q_item_t q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_FIRST_ID:       cfg_nxt.first_id       = cfg_wdata[ID_W-1:0];
        REG_SET_TILE_COUNT: cfg_nxt.set_tile_count = cfg_wdata[CNT_W-1:0];
        REG_TILES_PER_ROW:  cfg_nxt.tiles_per_row  = cfg_wdata[TPR_W-1:0];
        REG_TILE_WIDTH:     cfg_nxt.tile_width     = cfg_wdata[TSZ_W-1:0];
        REG_TILE_HEIGHT:    cfg_nxt.tile_height    = cfg_wdata[TSZ_W-1:0];
        REG_TEXTURE_WIDTH:  cfg_nxt.texture_width  = cfg_wdata[TEX_DIM_W-1:0];
        REG_TEXTURE_HEIGHT: cfg_nxt.texture_height = cfg_wdata[TEX_DIM_W-1:0];
        REG_TINT_RGBA:      cfg_nxt.tint_rgba      = cfg_wdata[RGBA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // zero divisors act as one
  always_comb begin
    cfg_eff = cfg_r;
    if (cfg_r.tiles_per_row == '0) begin
      cfg_eff.tiles_per_row = TPR_W'(1);
    end
    if (cfg_r.texture_width == '0) begin
      cfg_eff.texture_width = TEX_DIM_W'(1);
    end
    if (cfg_r.texture_height == '0) begin
      cfg_eff.texture_height = TEX_DIM_W'(1);
    end
  end

  tqv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_eff),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_wdata (q_wdata)
  );

  tqv_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  tqv_back #(
    .UV_FRAC_BITS (UV_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_eff),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
